// ===== rtl/core/fdc_pkg.sv =====
// Shared types and constants for the fader deadband and calibration block.
`timescale 1ns / 1ps
`default_nettype none
package fdc_pkg;

	localparam int DATA_W           = 12;
	localparam int CH_W             = 3;
	localparam int NUM_CHANNELS_DEF = 8;
	localparam int ADC_LEVELS_DEF   = 4096;
	localparam int DATA_MAX         = (1 << DATA_W) - 1;

	localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(8);

	// request kinds
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_CAL    = 1'b1;

	// configuration map
	localparam int          APB_AW           = 3;
	localparam int          APB_DW           = 32;
	localparam logic        REG_NOISE_TOL    = 1'b0;

	// job queue between front and back
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW    = 2;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic              changed;
		logic [DATA_W-1:0] raw;
		logic              zero;
		logic [DATA_W-1:0] delta;
		logic [DATA_W-1:0] span;
	} fdc_job_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic              changed;
		logic [DATA_W-1:0] raw;
		logic [DATA_W-1:0] scaled;
	} fdc_result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_WB
	} fdc_back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/fdc_front.sv =====
// Front end: channel tables, deadband check and job classification.
`timescale 1ns / 1ps
`default_nettype none
module fdc_front #(
	parameter int NUM_CHANNELS = fdc_pkg::NUM_CHANNELS_DEF,
	parameter int ADC_LEVELS   = fdc_pkg::ADC_LEVELS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      take,
	input  wire logic                      mode,
	input  wire logic [fdc_pkg::CH_W-1:0]  channel,
	input  wire logic [fdc_pkg::DATA_W-1:0] sample,
	input  wire logic [fdc_pkg::DATA_W-1:0] cal_low,
	input  wire logic [fdc_pkg::DATA_W-1:0] cal_high,
	input  wire logic [fdc_pkg::DATA_W-1:0] tol,
	output fdc_pkg::fdc_job_t              job,
	output logic                           job_push
);
	import fdc_pkg::*;

	localparam int TBL_DEPTH = NUM_CHANNELS;
	localparam int IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int FULL_CODE = ADC_LEVELS - 1;
	localparam logic [DATA_W-1:0] HIGH_RESET =
		(FULL_CODE > DATA_MAX) ? DATA_W'(DATA_MAX) : DATA_W'(FULL_CODE);

	logic [DATA_W-1:0] acc_q  [TBL_DEPTH];
	logic [DATA_W-1:0] low_q  [TBL_DEPTH];
	logic [DATA_W-1:0] high_q [TBL_DEPTH];

	logic              ch_ok;
	logic [IDX_W-1:0]  idx;
	logic [DATA_W-1:0] prev;
	logic [DATA_W-1:0] lo;
	logic [DATA_W-1:0] hi;
	logic [DATA_W-1:0] diff;
	logic [DATA_W-1:0] clamped;
	logic              chg;

	assign ch_ok = 32'(channel) < 32'(NUM_CHANNELS);
	assign idx   = ch_ok ? IDX_W'(channel) : '0;
	assign prev  = acc_q[idx];
	assign lo    = low_q[idx];
	assign hi    = high_q[idx];

	always_comb begin
		diff    = (sample >= prev) ? (sample - prev) : (prev - sample);
		chg     = ch_ok && (diff > tol);
		clamped = sample;
		if (clamped < lo) begin
			clamped = lo;
		end
		if (clamped > hi) begin
			clamped = hi;
		end
	end

	always_comb begin
		job.channel = channel;
		job.changed = chg;
		job.raw     = sample;
		job.zero    = !ch_ok || (hi <= lo);
		job.delta   = clamped - lo;
		job.span    = hi - lo;
		job_push    = take && (mode == MODE_SAMPLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TBL_DEPTH; i++) begin
				acc_q[i]  <= '0;
				low_q[i]  <= '0;
				high_q[i] <= HIGH_RESET;
			end
		end else if (take && ch_ok) begin
			if (mode == MODE_CAL) begin
				low_q[idx]  <= cal_low;
				high_q[idx] <= cal_high;
			end else if (chg) begin
				acc_q[idx] <= sample;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fdc_queue.sv =====
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module fdc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire fdc_pkg::fdc_job_t wr_job,
	input  wire logic              pop,
	output fdc_pkg::fdc_job_t      rd_job,
	output logic                   full,
	output logic                   empty
);
	import fdc_pkg::*;

	fdc_job_t           slot_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wr_ptr_q;
	logic [JOBQ_AW-1:0] rd_ptr_q;
	logic [JOBQ_AW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = count_q == (JOBQ_AW+1)'(JOBQ_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fdc_back.sv =====
// Back end: scale multiply, bit-serial divide and result register.
`timescale 1ns / 1ps
`default_nettype none
module fdc_back #(
	parameter int ADC_LEVELS = fdc_pkg::ADC_LEVELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fdc_pkg::fdc_job_t job,
	input  wire logic              job_empty,
	output logic                   job_pop,
	input  wire logic              res_pop,
	output fdc_pkg::fdc_result_t   res,
	output logic                   res_valid
);
	import fdc_pkg::*;

	localparam int Q_W   = $clog2(ADC_LEVELS);
	localparam int P_W   = DATA_W + Q_W;
	localparam int CNT_W = $clog2(Q_W);
	localparam logic [Q_W-1:0] FULL_CODE = Q_W'(ADC_LEVELS - 1);

	fdc_back_state_t state_q;
	fdc_back_state_t state_d;

	fdc_job_t          job_q;
	logic [DATA_W-1:0] rem_q;
	logic [Q_W-1:0]    low_q;
	logic [Q_W-1:0]    quo_q;
	logic [CNT_W-1:0]  cnt_q;
	fdc_result_t       res_q;
	logic              res_valid_q;

	logic [P_W-1:0]    product;
	logic [DATA_W:0]   trial;
	logic              qbit;
	logic              slot_free;
	logic              last_step;
	logic [DATA_W-1:0] scaled;

	logic ld_job;
	logic do_mul;
	logic do_div;
	logic do_wb;

	assign product   = P_W'(job_q.delta) * P_W'(FULL_CODE);
	assign trial     = {rem_q, low_q[Q_W-1]};
	assign qbit      = trial >= {1'b0, job_q.span};
	assign slot_free = !res_valid_q || res_pop;
	assign last_step = cnt_q == CNT_W'(Q_W - 1);
	assign scaled    = job_q.zero ? '0 :
		(32'(quo_q) > 32'(DATA_MAX)) ? DATA_W'(DATA_MAX) : DATA_W'(quo_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					state_d = job.zero ? BK_WB : BK_MUL;
				end
			end
			BK_MUL: state_d = BK_DIV;
			BK_DIV: begin
				if (last_step) begin
					state_d = BK_WB;
				end
			end
			BK_WB: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		ld_job = 1'b0;
		do_mul = 1'b0;
		do_div = 1'b0;
		do_wb  = 1'b0;
		unique case (state_q)
			BK_IDLE: ld_job = !job_empty;
			BK_MUL:  do_mul = 1'b1;
			BK_DIV:  do_div = 1'b1;
			BK_WB:   do_wb  = slot_free;
			default: ;
		endcase
	end

	assign job_pop = ld_job;

	always_ff @(posedge clk) begin
		if (ld_job) begin
			job_q <= job;
			quo_q <= '0;
		end
		if (do_mul) begin
			rem_q <= product[P_W-1:Q_W];
			low_q <= product[Q_W-1:0];
		end
		if (do_div) begin
			rem_q <= qbit ? DATA_W'(trial - {1'b0, job_q.span}) : trial[DATA_W-1:0];
			low_q <= {low_q[Q_W-2:0], 1'b0};
			quo_q <= {quo_q[Q_W-2:0], qbit};
		end
		if (do_wb) begin
			res_q.channel <= job_q.channel;
			res_q.changed <= job_q.changed;
			res_q.raw     <= job_q.raw;
			res_q.scaled  <= scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_mul) begin
				cnt_q <= '0;
			end else if (do_div) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (do_wb) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/fader_deadband_calibrate_top.sv =====
// Top level of the fader deadband detector with linear calibration.
`timescale 1ns / 1ps
`default_nettype none
// Each request is either an ADC sample or a calibration write for one fader channel.
// A calibration request loads that channel's low and high points and gives no result;
// it never reaches the back end. A sample request is checked against the channel's last
// accepted value (changed is set, and the value stored, when the distance exceeds
// noise_tolerance) and then mapped into the output range as (clamp(sample) - low) *
// (ADC_LEVELS-1) / (high - low); an equal or inverted span, or a channel at or beyond
// NUM_CHANNELS, gives a scaled value of 0. The front end takes one request per cycle
// while its four-entry job queue has room. The back end runs one sample at a time,
// through a multiply, a restoring divide that retires one quotient bit a cycle, and a
// write-back that waits for the output register to be free; a sample that needs no
// divide goes straight to write-back. Results wait in a one-entry output register, and
// the front keeps taking requests while one sits there unread.
// noise_tolerance lives at byte address 0 of the APB-style port (reset 8) and should
// only be written while the block is idle. No clearing pass is needed after reset.
module fader_deadband_calibrate_top #(
	parameter int NUM_CHANNELS = fdc_pkg::NUM_CHANNELS_DEF,
	parameter int ADC_LEVELS   = fdc_pkg::ADC_LEVELS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request side
	input  wire logic                        push,
	output logic                             full,
	input  wire logic                        mode,
	input  wire logic [fdc_pkg::CH_W-1:0]    channel,
	input  wire logic [fdc_pkg::DATA_W-1:0]  sample,
	input  wire logic [fdc_pkg::DATA_W-1:0]  cal_low,
	input  wire logic [fdc_pkg::DATA_W-1:0]  cal_high,
	// result side
	output logic                             empty,
	input  wire logic                        pop,
	output logic [fdc_pkg::CH_W-1:0]         out_channel,
	output logic                             changed,
	output logic [fdc_pkg::DATA_W-1:0]       raw_value,
	output logic [fdc_pkg::DATA_W-1:0]       scaled_value,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fdc_pkg::APB_AW-1:0]  paddr,
	input  wire logic [fdc_pkg::APB_DW-1:0]  pwdata,
	output logic [fdc_pkg::APB_DW-1:0]       prdata,
	output logic                             pready
);
	import fdc_pkg::*;

	logic [DATA_W-1:0] tol_q;
	logic              take;
	logic              cfg_wr;
	logic              reg_hit;

	fdc_job_t    fe_job;
	logic        fe_push;
	fdc_job_t    q_job;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	fdc_result_t be_res;
	logic        be_valid;

	// register decode ignores the byte offset bits
	assign pready  = 1'b1;
	assign reg_hit = paddr[APB_AW-1] == REG_NOISE_TOL;
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? APB_DW'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr) begin
			tol_q <= pwdata[DATA_W-1:0];
		end
	end

	// calibration requests are held back too when the queue is full, which keeps
	// table updates in order with the samples ahead of them
	assign full = q_full;
	assign take = push && !q_full;

	fdc_front #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.ADC_LEVELS  (ADC_LEVELS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.mode    (mode),
		.channel (channel),
		.sample  (sample),
		.cal_low (cal_low),
		.cal_high(cal_high),
		.tol     (tol_q),
		.job     (fe_job),
		.job_push(fe_push)
	);

	fdc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fe_push),
		.wr_job(fe_job),
		.pop   (q_pop),
		.rd_job(q_job),
		.full  (q_full),
		.empty (q_empty)
	);

	fdc_back #(
		.ADC_LEVELS(ADC_LEVELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (q_job),
		.job_empty(q_empty),
		.job_pop  (q_pop),
		.res_pop  (pop),
		.res      (be_res),
		.res_valid(be_valid)
	);

	assign empty        = !be_valid;
	assign out_channel  = be_res.channel;
	assign changed      = be_res.changed;
	assign raw_value    = be_res.raw;
	assign scaled_value = be_res.scaled;

endmodule
`default_nettype wire

// ===== rtl/core/fdc_checker.sv =====
// Port-level checks for the fader deadband block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fdc_checker #(
	parameter int NUM_CHANNELS = fdc_pkg::NUM_CHANNELS_DEF
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        empty,
	input wire logic                        pop,
	input wire logic [fdc_pkg::CH_W-1:0]    out_channel,
	input wire logic                        changed,
	input wire logic [fdc_pkg::DATA_W-1:0]  raw_value,
	input wire logic [fdc_pkg::DATA_W-1:0]  scaled_value,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic [fdc_pkg::APB_AW-1:0]  paddr,
	input wire logic [fdc_pkg::APB_DW-1:0]  pwdata,
	input wire logic [fdc_pkg::APB_DW-1:0]  prdata
);
	import fdc_pkg::*;

	// no result survives a reset cycle
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result present after reset");

	// a result for a channel outside the table is never flagged nor scaled
	a_bad_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (32'(out_channel) >= 32'(NUM_CHANNELS)))
		|-> (!changed && (scaled_value == '0)))
		else $error("out-of-range channel gave a change or a scaled value");

	// an unread result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(raw_value) && $stable(scaled_value)
			&& $stable(out_channel) && $stable(changed)))
		else $error("waiting result changed");

	// tolerance register reads back what was written
	a_tol_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[APB_AW-1] == REG_NOISE_TOL))
		|=> ((paddr[APB_AW-1] != REG_NOISE_TOL)
			|| (prdata == APB_DW'($past(pwdata[DATA_W-1:0])))))
		else $error("tolerance register readback mismatch");

endmodule

bind fader_deadband_calibrate_top fdc_checker #(
	.NUM_CHANNELS(NUM_CHANNELS)
) u_fdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.out_channel (out_channel),
	.changed     (changed),
	.raw_value   (raw_value),
	.scaled_value(scaled_value),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata)
);
`default_nettype wire
